### hdl/mhd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the magnetometer heading block.
// No dependencies.
package mhd_pkg;

    localparam int FIELD_W        = 17;
    localparam int RAW_W          = 16;
    localparam int HEAD_W         = 15;
    localparam int THR_W          = 8;
    localparam int DECL_W         = 15;
    localparam int CFG_IDX_W      = 2;
    localparam int ANGLE_W        = 32;
    localparam int MUL_A_W        = 32;
    localparam int MUL_B_W        = 24;
    localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
    localparam int SCALE_W        = 23;
    localparam int RECIP_SHIFT    = 30;
    localparam int QUOT_W         = 16;
    localparam int CORDIC_W       = 28;
    localparam int PRESHIFT       = 8;
    localparam int CORDIC_STEPS   = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int CORDIC_RUN     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W         = $clog2(ATAN_ENTRIES);
    localparam int HEADING_FULL   = 23040;
    localparam int NUM_AXES       = 3;
    localparam int AXIS_W         = $clog2(NUM_AXES);

    // floor(x / 109) == (x * RECIP_109) >> 30 for every scaled magnitude
    localparam logic [MUL_B_W-1:0] RECIP_109   = MUL_B_W'((64'd1 << RECIP_SHIFT) / 109 + 1);
    localparam logic [MUL_B_W-1:0] HEADING_MUL = MUL_B_W'(HEADING_FULL);
    localparam logic [SCALE_W-1:0] ROUND_BIAS  = SCALE_W'(54);
    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(5);

    localparam logic [CFG_IDX_W-1:0] REG_ERROR_THRESHOLD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION_OFFSET = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ROTATE,
        ST_HEAD,
        ST_HEAD_WAIT,
        ST_DONE
    } mhd_state_t;

    typedef struct packed {
        logic start;
    } mhd_cordic_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mhd_cordic_stat_t;

    // arctangent of 2^-i, full circle = 2^32
    function automatic logic [ANGLE_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ANGLE_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2F9;
            5'd15:   val = 32'h0000517C;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A2F;
            5'd19:   val = 32'h00000517;
            5'd20:   val = 32'h0000028B;
            5'd21:   val = 32'h00000145;
            5'd22:   val = 32'h000000A2;
            5'd23:   val = 32'h00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### hdl/mhd_mult.sv
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on mhd_pkg.
module mhd_mult
    import mhd_pkg::*;
(
    input  logic               aclk,
    input  logic [MUL_A_W-1:0] mul_a,
    input  logic [MUL_B_W-1:0] mul_b,
    output logic [MUL_P_W-1:0] mul_p
);

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
    end

    assign mul_p = prod_reg;

endmodule

### hdl/mhd_cordic.sv
`timescale 1ns / 1ps
// Iterative vectoring CORDIC: one shift-add rotation per cycle, angle in 2^-32 turns.
// Depends on mhd_pkg.
module mhd_cordic
    import mhd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mhd_cordic_ctl_t            ctl,
    input  logic signed [FIELD_W-1:0]  x_in,
    input  logic signed [FIELD_W-1:0]  y_in,
    output logic [ANGLE_W-1:0]         angle,
    output mhd_cordic_stat_t           stat
);

    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic [ANGLE_W-1:0]         ang_reg, ang_next;
    logic                       zero_reg, zero_next;
    logic                       busy_reg, busy_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic signed [CORDIC_W-1:0] x_init, y_init, x_sh, y_sh;
    logic                       y_pos, last_step;

    assign x_init = {{(CORDIC_W-FIELD_W-PRESHIFT){x_in[FIELD_W-1]}}, x_in, {PRESHIFT{1'b0}}};
    assign y_init = {{(CORDIC_W-FIELD_W-PRESHIFT){y_in[FIELD_W-1]}}, y_in, {PRESHIFT{1'b0}}};
    assign x_sh      = x_reg >>> step_reg;
    assign y_sh      = y_reg >>> step_reg;
    assign y_pos     = !y_reg[CORDIC_W-1] && (|y_reg);
    assign last_step = (step_reg == STEP_W'(CORDIC_RUN - 1));

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        ang_next  = ang_reg;
        zero_next = zero_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        if (ctl.start) begin
            zero_next = (x_in == '0) && (y_in == '0);
            step_next = '0;
            busy_next = 1'b1;
            if (x_in[FIELD_W-1]) begin
                x_next   = -x_init;
                y_next   = -y_init;
                ang_next = {1'b1, {(ANGLE_W-1){1'b0}}};
            end else begin
                x_next   = x_init;
                y_next   = y_init;
                ang_next = '0;
            end
        end else if (busy_reg) begin
            if (y_pos) begin
                x_next   = x_reg + y_sh;
                y_next   = y_reg - x_sh;
                ang_next = ang_reg + atan_entry(step_reg);
            end else begin
                x_next   = x_reg - y_sh;
                y_next   = y_reg + x_sh;
                ang_next = ang_reg - atan_entry(step_reg);
            end
            step_next = step_reg + STEP_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        ang_reg  <= ang_next;
        zero_reg <= zero_next;
    end

    assign angle     = zero_reg ? '0 : ang_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last_step;

endmodule

### hdl/magnetometer_heading_top.sv
`timescale 1ns / 1ps
// Magnetometer heading block: sequencer, held state, output register and config registers.
// Depends on mhd_pkg, mhd_mult and mhd_cordic.
//
// Usage:
//   s_ channel: one request per sensor read. s_tuser carries the success flag, s_tdata
//   the raw X, Y and Z counts. m_ channel: one result per request with the held field
//   values, heading and the valid flag. cfg_ channel: register writes (index 0 error
//   threshold, index 1 declination); cfg_ready is always high, other indexes are dropped.
//   Write registers only while the block is idle.
// Sequence:
//   A successful read scales the axes on the shared multiplier, runs one CORDIC
//   rotation per cycle, then scales and wraps the heading: m_tvalid rises the same
//   cycle that s_tready returns, so the next request is taken only after the last is
//   done. A failed read goes straight to ST_DONE.
// Reset:
//   Held values and heading clear, valid flag sets, failure count clears, threshold 5,
//   declination 0. The output register empties.
// Stall:
//   A finished result waits in the output register; the block takes the next request,
//   works it, and holds its completion until the output register frees.
module magnetometer_heading_top
    import mhd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,    // raw_x[15:0], raw_y[31:16], raw_z[47:32]
    input  logic [0:0]            s_tuser,    // read_ok[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,    // field_x[16:0], field_y[33:17], field_z[50:34],
                                              // heading[65:51], zero pad[71:66]
    output logic [0:0]            m_tuser,    // data_valid[0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DECL_W-1:0]     cfg_data
);

    mhd_state_t                  state_reg, state_next;
    logic [AXIS_W-1:0]           cnt_reg, cnt_next;
    logic signed [RAW_W-1:0]     raw_reg [NUM_AXES];
    logic signed [RAW_W-1:0]     raw_next [NUM_AXES];
    logic signed [FIELD_W-1:0]   held_reg [NUM_AXES];
    logic signed [FIELD_W-1:0]   held_next [NUM_AXES];
    logic [HEAD_W-1:0]           heading_reg, heading_next;
    logic                        valid_reg, valid_next;
    logic [THR_W-1:0]            fail_reg, fail_next;
    logic [THR_W-1:0]            thr_reg;
    logic [DECL_W-1:0]           decl_reg;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [71:0]                 m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic [MUL_P_W-1:0]          mul_p;
    logic [ANGLE_W-1:0]          angle;
    mhd_cordic_ctl_t             cordic_ctl;
    mhd_cordic_stat_t            cordic_stat;

    logic                        accept;
    logic [AXIS_W-1:0]           issue_axis, cap_axis;
    logic signed [RAW_W-1:0]     issue_raw;
    logic [RAW_W:0]              issue_mag;
    logic [SCALE_W-1:0]          issue_scaled;
    logic [QUOT_W-1:0]           quot;
    logic [MUL_P_W-1:0]          head_sum;
    logic [HEAD_W-1:0]           head_raw, head_base;
    logic signed [HEAD_W+1:0]    head_t;
    logic [HEAD_W-1:0]           head_wrapped;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // axis scaling operands: |raw| * 160 + 54, then floor divide by 109
    assign issue_axis   = (cnt_reg == AXIS_W'(NUM_AXES)) ? '0 : cnt_reg;
    assign cap_axis     = cnt_reg - AXIS_W'(1);
    assign issue_raw    = raw_reg[issue_axis];
    assign issue_mag    = issue_raw[RAW_W-1] ? ((RAW_W+1)'(0) - {issue_raw[RAW_W-1], issue_raw})
                                             : {issue_raw[RAW_W-1], issue_raw};
    assign issue_scaled = ({{(SCALE_W-RAW_W-1){1'b0}}, issue_mag} << 7)
                        + ({{(SCALE_W-RAW_W-1){1'b0}}, issue_mag} << 5) + ROUND_BIAS;
    assign quot         = mul_p[RECIP_SHIFT +: QUOT_W];

    // heading scale, round, declination offset, wrap
    assign head_sum     = mul_p + {{(MUL_P_W-ANGLE_W){1'b0}}, 1'b1, {(ANGLE_W-1){1'b0}}};
    assign head_raw     = head_sum[ANGLE_W +: HEAD_W];
    assign head_base    = (head_raw >= HEAD_W'(HEADING_FULL)) ? '0 : head_raw;
    assign head_t       = $signed({2'b00, head_base})
                        + $signed({{2{decl_reg[DECL_W-1]}}, decl_reg});
    always_comb begin
        if (head_t < 0) begin
            head_wrapped = HEAD_W'(head_t + (HEAD_W+2)'(HEADING_FULL));
        end else if (head_t >= (HEAD_W+2)'(HEADING_FULL)) begin
            head_wrapped = HEAD_W'(head_t - (HEAD_W+2)'(HEADING_FULL));
        end else begin
            head_wrapped = HEAD_W'(head_t);
        end
    end

    always_comb begin
        mul_b = RECIP_109;
        mul_a = {{(MUL_A_W-SCALE_W){1'b0}}, issue_scaled};
        if (state_reg == ST_HEAD) begin
            mul_a = angle;
            mul_b = HEADING_MUL;
        end
    end

    mhd_mult u_mult (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    mhd_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cordic_ctl),
        .x_in    (held_reg[0]),
        .y_in    (held_reg[1]),
        .angle   (angle),
        .stat    (cordic_stat)
    );

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        raw_next         = raw_reg;
        held_next        = held_reg;
        heading_next     = heading_reg;
        valid_next       = valid_reg;
        fail_next        = fail_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        cordic_ctl.start = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0]) begin
                        raw_next[0] = s_tdata[15:0];
                        raw_next[1] = s_tdata[31:16];
                        raw_next[2] = s_tdata[47:32];
                        cnt_next    = '0;
                        state_next  = ST_SCALE;
                    end else begin
                        if (fail_reg < thr_reg) begin
                            fail_next = fail_reg + THR_W'(1);
                        end
                        if (fail_next >= thr_reg) begin
                            valid_next = 1'b0;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCALE: begin
                if (cnt_reg != '0) begin
                    held_next[cap_axis] = raw_reg[cap_axis][RAW_W-1]
                        ? (FIELD_W'(0) - {1'b0, quot}) : {1'b0, quot};
                end
                cnt_next = cnt_reg + AXIS_W'(1);
                if (cnt_reg == AXIS_W'(NUM_AXES)) begin
                    cordic_ctl.start = 1'b1;
                    state_next       = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                if (cordic_stat.done) begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                state_next = ST_HEAD_WAIT;
            end
            ST_HEAD_WAIT: begin
                heading_next = head_wrapped;
                valid_next   = 1'b1;
                fail_next    = '0;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, heading_reg, held_reg[2], held_reg[1], held_reg[0]};
                    m_tuser_next  = valid_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            held_reg     <= '{default: '0};
            heading_reg  <= '0;
            valid_reg    <= 1'b1;
            fail_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            thr_reg      <= THR_RESET;
            decl_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            held_reg     <= held_next;
            heading_reg  <= heading_next;
            valid_reg    <= valid_next;
            fail_reg     <= fail_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ERROR_THRESHOLD) begin
                    thr_reg <= cfg_data[THR_W-1:0];
                end else if (cfg_index == REG_DECLINATION_OFFSET) begin
                    decl_reg <= cfg_data;
                end
            end
        end
        raw_reg     <= raw_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_fail_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_tuser[0]) |=> (state_reg == ST_DONE))
        else $error("failed read did not complete directly");

    a_ok_scales: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser[0]) |=> (state_reg == ST_SCALE && cnt_reg == '0))
        else $error("good read did not start scaling");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        heading_reg < HEAD_W'(HEADING_FULL))
        else $error("held heading out of range");

    a_cordic_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_stat.busy |-> (state_reg == ST_ROTATE))
        else $error("rotation running outside rotate state");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> $stable(m_tdata_reg))
        else $error("pending result overwritten");

endmodule
